### sv/buzzer_melody_sequencer_defines.svh
`ifndef BUZZER_MELODY_SEQUENCER_DEFINES_SVH
`define BUZZER_MELODY_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define BMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bms: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define BMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bms: next-cycle check failed");

`endif

### sv/bms_pkg.sv
package bms_pkg;

  localparam int NUM_SOUNDS        = 16;
  localparam int NOTES_PER_SOUND   = 64;
  localparam int START_DELAY_TICKS = 100;
  localparam int TICKS_PER_UNIT    = 100;

  localparam int STORE_DEPTH = NUM_SOUNDS * NOTES_PER_SOUND;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = $clog2(NOTES_PER_SOUND);

  localparam int FUNC_W    = 2;
  localparam int SOUND_W   = 4;
  localparam int INDEX_W   = 6;
  localparam int FREQ_W    = 16;
  localparam int DUR_W     = 8;
  localparam int VOL_W     = 8;
  localparam int ELAPSED_W = 15;
  localparam int COUNT_W   = 7;
  localparam int LIMIT_W   = ELAPSED_W + 1;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [COUNT_W-1:0]   START_COUNT = COUNT_W'(START_DELAY_TICKS);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_PLAY = 2'd1,
    FUNC_STOP = 2'd2,
    FUNC_LOAD = 2'd3
  } func_t;

  typedef struct packed {
    logic [DUR_W-1:0]  duration;
    logic [FREQ_W-1:0] frequency;
  } slot_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SOUND_W-1:0] snd,
                                                  input logic [POS_W:0] pos);
    return ADDR_W'(32'(snd) * NOTES_PER_SOUND + 32'(pos));
  endfunction

endpackage

### sv/buzzer_melody_sequencer.sv
// Buzzer melody sequencer.
// Input channel (in_valid/in_ready) carries one command item: tick of 1 ms,
// play, stop, or load of one note slot (frequency, duration in 100-tick units).
// Output channel (out_valid/out_ready) returns one status item per command:
// tone on flag, tone frequency, latched volume, busy flag and a note-start pulse.
// The accepted item is held in the s1 stage register; it commits into the output
// register once that register is free, and the result is offered from there.
// No new item is taken while one is held. The note memory is read at acceptance
// and the sequencer state is updated from the read data when the item commits;
// the next item is taken once that update has been written back.
// A finished result waits in the output register; a new item is still taken
// while it waits, and processing of that item holds until the output frees.
// Reset clears playback state and both channels; note slots are not cleared and
// must be loaded before a sound that uses them is played. No clearing pass.
`include "buzzer_melody_sequencer_defines.svh"

module buzzer_melody_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bms_pkg::FUNC_W-1:0]    func,
  input  logic [bms_pkg::SOUND_W-1:0]   sound_index,
  input  logic [bms_pkg::INDEX_W-1:0]   note_index,
  input  logic [bms_pkg::FREQ_W-1:0]    note_frequency,
  input  logic [bms_pkg::DUR_W-1:0]     note_duration,
  input  logic [bms_pkg::VOL_W-1:0]     volume_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          tone_on,
  output logic [bms_pkg::FREQ_W-1:0]    tone_frequency,
  output logic [bms_pkg::VOL_W-1:0]     tone_volume,
  output logic                          busy_res,
  output logic                          note_started
);

  bms_pkg::slot_t mem [bms_pkg::STORE_DEPTH];
  bms_pkg::slot_t rd_data;
  bms_pkg::slot_t cur_slot, cur_slot_next;

  logic                             s1_valid;
  bms_pkg::func_t                   s1_func;
  logic [bms_pkg::SOUND_W-1:0]      s1_sound;
  logic [bms_pkg::INDEX_W-1:0]      s1_index;
  logic [bms_pkg::FREQ_W-1:0]       s1_freq;
  logic [bms_pkg::DUR_W-1:0]        s1_dur;
  logic [bms_pkg::VOL_W-1:0]        s1_vol;
  logic [bms_pkg::POS_W:0]          s1_next_pos;

  logic [bms_pkg::SOUND_W-1:0]      active_sound, active_sound_next;
  logic [bms_pkg::POS_W-1:0]        note_position, note_position_next;
  logic [bms_pkg::ELAPSED_W-1:0]    note_elapsed, note_elapsed_next;
  logic [bms_pkg::COUNT_W-1:0]      start_countdown, start_countdown_next;
  logic                             start_pending, start_pending_next;
  logic                             playing_flag, playing_flag_next;
  logic                             sounding_flag, sounding_flag_next;
  logic [bms_pkg::VOL_W-1:0]        latched_volume, latched_volume_next;

  logic                             accept;
  logic                             commit;
  logic [bms_pkg::POS_W:0]          rd_pos;
  logic [bms_pkg::ADDR_W-1:0]       rd_addr;
  logic [bms_pkg::ADDR_W-1:0]       wr_addr;
  logic                             mem_we;
  logic                             load_ok;
  logic                             load_hit;
  logic [bms_pkg::COUNT_W-1:0]      count_dec;
  logic [bms_pkg::ELAPSED_W-1:0]    elapsed_inc;
  logic [bms_pkg::LIMIT_W-1:0]      note_limit;
  logic                             begin_try;
  logic                             halt;
  logic                             started;

  assign in_ready = !s1_valid;
  assign accept   = in_valid && in_ready;
  assign commit   = s1_valid && (!out_valid || out_ready);

  assign rd_pos  = start_pending ? '0 : ({1'b0, note_position} + 1'b1);
  assign rd_addr = bms_pkg::slot_addr(active_sound, rd_pos);

  assign load_ok  = (32'(s1_sound) < bms_pkg::NUM_SOUNDS) &&
                    (32'(s1_index) < bms_pkg::NOTES_PER_SOUND);
  assign load_hit = (s1_sound == active_sound) && (32'(s1_index) == 32'(note_position));
  assign wr_addr  = bms_pkg::slot_addr(s1_sound, (bms_pkg::POS_W + 1)'(s1_index));
  assign mem_we   = commit && (s1_func == bms_pkg::FUNC_LOAD) && load_ok;

  assign count_dec   = (start_countdown != '0) ? start_countdown - 1'b1 : '0;
  assign elapsed_inc = (note_elapsed == bms_pkg::ELAPSED_MAX) ? note_elapsed
                                                              : note_elapsed + 1'b1;
  assign note_limit  = bms_pkg::LIMIT_W'(32'(cur_slot.duration) * bms_pkg::TICKS_PER_UNIT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= bms_pkg::slot_t'({s1_dur, s1_freq});
    end
    if (accept) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    active_sound_next    = active_sound;
    note_position_next   = note_position;
    note_elapsed_next    = note_elapsed;
    start_countdown_next = start_countdown;
    start_pending_next   = start_pending;
    playing_flag_next    = playing_flag;
    sounding_flag_next   = sounding_flag;
    latched_volume_next  = latched_volume;
    cur_slot_next        = cur_slot;
    begin_try            = 1'b0;
    halt                 = 1'b0;
    started              = 1'b0;

    unique case (s1_func)
      bms_pkg::FUNC_TICK: begin
        if (start_pending) begin
          start_countdown_next = count_dec;
          if (count_dec == '0) begin
            start_pending_next = 1'b0;
            begin_try          = 1'b1;
          end
        end else if (sounding_flag) begin
          note_elapsed_next = elapsed_inc;
          if ({1'b0, elapsed_inc} >= note_limit) begin
            begin_try = 1'b1;
          end
        end
      end
      bms_pkg::FUNC_PLAY: begin
        if (32'(s1_sound) < bms_pkg::NUM_SOUNDS) begin
          active_sound_next    = s1_sound;
          latched_volume_next  = s1_vol;
          playing_flag_next    = 1'b1;
          start_pending_next   = 1'b1;
          sounding_flag_next   = 1'b0;
          note_position_next   = '0;
          note_elapsed_next    = '0;
          start_countdown_next = bms_pkg::START_COUNT;
        end
      end
      bms_pkg::FUNC_STOP: begin
        halt = 1'b1;
      end
      bms_pkg::FUNC_LOAD: begin
        if (load_ok && load_hit) begin
          cur_slot_next = bms_pkg::slot_t'({s1_dur, s1_freq});
        end
      end
      default: begin
        halt = 1'b0;
      end
    endcase

    if (begin_try) begin
      if ((32'(s1_next_pos) >= bms_pkg::NOTES_PER_SOUND) || (rd_data.frequency == '0)) begin
        halt = 1'b1;
      end else begin
        note_position_next = s1_next_pos[bms_pkg::POS_W-1:0];
        note_elapsed_next  = '0;
        sounding_flag_next = 1'b1;
        cur_slot_next      = rd_data;
        started            = 1'b1;
      end
    end

    if (halt) begin
      playing_flag_next  = 1'b0;
      start_pending_next = 1'b0;
      sounding_flag_next = 1'b0;
      note_elapsed_next  = '0;
    end
  end

  // hold the accepted item until its update commits
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func     <= bms_pkg::func_t'(func);
      s1_sound    <= sound_index;
      s1_index    <= note_index;
      s1_freq     <= note_frequency;
      s1_dur      <= note_duration;
      s1_vol      <= volume_in;
      s1_next_pos <= rd_pos;
    end
    if (commit) begin
      cur_slot       <= cur_slot_next;
      tone_on        <= sounding_flag_next;
      tone_frequency <= sounding_flag_next ? cur_slot_next.frequency : '0;
      tone_volume    <= latched_volume_next;
      busy_res       <= playing_flag_next;
      note_started   <= started;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      active_sound    <= '0;
      note_position   <= '0;
      note_elapsed    <= '0;
      start_countdown <= '0;
      start_pending   <= 1'b0;
      playing_flag    <= 1'b0;
      sounding_flag   <= 1'b0;
      latched_volume  <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        out_valid       <= 1'b1;
        active_sound    <= active_sound_next;
        note_position   <= note_position_next;
        note_elapsed    <= note_elapsed_next;
        start_countdown <= start_countdown_next;
        start_pending   <= start_pending_next;
        playing_flag    <= playing_flag_next;
        sounding_flag   <= sounding_flag_next;
        latched_volume  <= latched_volume_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BMS_ASSERT_NOW(a_start_sounds, out_valid && note_started, tone_on)
  `BMS_ASSERT_NOW(a_tone_busy, out_valid && tone_on, busy_res)
  `BMS_ASSERT_NOW(a_silent_zero, out_valid && !tone_on, tone_frequency == '0)
  `BMS_ASSERT_NOW(a_pending_state, start_pending, playing_flag && !sounding_flag)
  `BMS_ASSERT_NEXT(a_accept_holds, in_valid && in_ready, s1_valid && !in_ready)

endmodule

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic                       on;
    logic [bms_pkg::FREQ_W-1:0] freq;
    logic [bms_pkg::VOL_W-1:0]  vol;
    logic                       busy;
    logic                       started;
  } tone_status_t;

  class melody_scoreboard;
    bms_pkg::slot_t            slots [bms_pkg::STORE_DEPTH];
    int unsigned               sound;
    int unsigned               position;
    int unsigned               elapsed;
    int unsigned               countdown;
    bit                        pending;
    bit                        playing;
    bit                        sounding;
    logic [bms_pkg::VOL_W-1:0] volume;
    tone_status_t              awaited [$];
    int unsigned               failures;

    function new();
      foreach (slots[i]) slots[i] = '0;
      sound = 0;
      position = 0;
      elapsed = 0;
      countdown = 0;
      pending = 0;
      playing = 0;
      sounding = 0;
      volume = '0;
      failures = 0;
    endfunction

    function bms_pkg::slot_t slot_at(int unsigned pos);
      if (pos >= bms_pkg::NOTES_PER_SOUND) return '0;
      return slots[sound * bms_pkg::NOTES_PER_SOUND + pos];
    endfunction

    function void silence();
      playing = 0;
      pending = 0;
      sounding = 0;
      elapsed = 0;
    endfunction

    function bit start_note(int unsigned pos);
      bms_pkg::slot_t cur;
      cur = slot_at(pos);
      if (pos >= bms_pkg::NOTES_PER_SOUND || cur.frequency == '0) begin
        silence();
        return 1'b0;
      end
      position = pos;
      elapsed = 0;
      sounding = 1;
      return 1'b1;
    endfunction

    function void note_item(bms_pkg::func_t f, logic [bms_pkg::SOUND_W-1:0] snd,
                            logic [bms_pkg::INDEX_W-1:0] idx,
                            logic [bms_pkg::FREQ_W-1:0] freq,
                            logic [bms_pkg::DUR_W-1:0] dur,
                            logic [bms_pkg::VOL_W-1:0] vol);
      tone_status_t   s;
      bms_pkg::slot_t cur;
      bit             started;
      started = 0;
      case (f)
        bms_pkg::FUNC_TICK: begin
          if (pending) begin
            if (countdown > 0) countdown--;
            if (countdown == 0) begin
              pending = 0;
              started = start_note(0);
            end
          end else if (sounding) begin
            cur = slot_at(position);
            if (elapsed < bms_pkg::ELAPSED_MAX) elapsed++;
            if (elapsed >= int'(cur.duration) * bms_pkg::TICKS_PER_UNIT)
              started = start_note(position + 1);
          end
        end
        bms_pkg::FUNC_PLAY: begin
          if (snd < bms_pkg::NUM_SOUNDS) begin
            sound = snd;
            volume = vol;
            playing = 1;
            pending = 1;
            sounding = 0;
            position = 0;
            elapsed = 0;
            countdown = bms_pkg::START_COUNT;
          end
        end
        bms_pkg::FUNC_STOP: silence();
        bms_pkg::FUNC_LOAD: begin
          if (snd < bms_pkg::NUM_SOUNDS && idx < bms_pkg::NOTES_PER_SOUND)
            slots[snd * bms_pkg::NOTES_PER_SOUND + idx] = {dur, freq};
        end
        default: ;
      endcase
      cur = slot_at(position);
      s.on = sounding;
      s.freq = sounding ? cur.frequency : '0;
      s.vol = volume;
      s.busy = playing;
      s.started = started;
      awaited.push_back(s);
    endfunction

    function void report(string what, tone_status_t want, tone_status_t got);
      failures++;
      if (failures <= 10)
        $display({"%0t %s: expected on=%0b freq=%0d vol=%0d busy=%0b start=%0b,",
                  " got on=%0b freq=%0d vol=%0d busy=%0b start=%0b"},
                 $time, what, want.on, want.freq, want.vol, want.busy, want.started,
                 got.on, got.freq, got.vol, got.busy, got.started);
    endfunction

    function void check_result(tone_status_t got);
      tone_status_t want;
      if (awaited.size() == 0) begin
        report("result with nothing outstanding", '0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.on !== want.on || got.freq !== want.freq || got.vol !== want.vol ||
          got.busy !== want.busy || got.started !== want.started)
        report("status mismatch", want, got);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [bms_pkg::FUNC_W-1:0]  func = '0;
  logic [bms_pkg::SOUND_W-1:0] sound_index = '0;
  logic [bms_pkg::INDEX_W-1:0] note_index = '0;
  logic [bms_pkg::FREQ_W-1:0]  note_frequency = '0;
  logic [bms_pkg::DUR_W-1:0]   note_duration = '0;
  logic [bms_pkg::VOL_W-1:0]   volume_in = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        tone_on;
  logic [bms_pkg::FREQ_W-1:0]  tone_frequency;
  logic [bms_pkg::VOL_W-1:0]   tone_volume;
  logic                        busy_res;
  logic                        note_started;

  melody_scoreboard sb = new();

  bit          written [bms_pkg::STORE_DEPTH];
  int          src_idle_pct = 37;
  int          snk_idle_pct = 37;
  bit          hold_output = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  buzzer_melody_sequencer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    tone_status_t got;
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_item(bms_pkg::func_t'(func), sound_index, note_index, note_frequency,
                     note_duration, volume_in);
      if (out_valid && out_ready) begin
        got = {tone_on, tone_frequency, tone_volume, busy_res, note_started};
        sb.check_result(got);
      end
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send(bms_pkg::func_t f, int snd, int idx, int freq, int dur, int vol);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    sound_index <= bms_pkg::SOUND_W'(snd);
    note_index <= bms_pkg::INDEX_W'(idx);
    note_frequency <= bms_pkg::FREQ_W'(freq);
    note_duration <= bms_pkg::DUR_W'(dur);
    volume_in <= bms_pkg::VOL_W'(vol);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic tick_n(int n);
    repeat (n)
      send(bms_pkg::FUNC_TICK, $urandom_range(15), $urandom_range(63),
           $urandom_range(65535), $urandom_range(255), $urandom_range(255));
  endtask

  task automatic stop_play();
    send(bms_pkg::FUNC_STOP, $urandom_range(15), $urandom_range(63), $urandom_range(65535),
         $urandom_range(255), $urandom_range(255));
  endtask

  task automatic play_sound(int s, int vol);
    send(bms_pkg::FUNC_PLAY, s, $urandom_range(63), $urandom_range(65535),
         $urandom_range(255), vol);
  endtask

  // keep every slot that a playing sound can reach loaded
  task automatic load_slot(int s, int n, int freq, int dur);
    if (freq != 0 && n < bms_pkg::NOTES_PER_SOUND - 1 &&
        !written[s * bms_pkg::NOTES_PER_SOUND + n + 1])
      freq = 0;
    written[s * bms_pkg::NOTES_PER_SOUND + n] = 1'b1;
    send(bms_pkg::FUNC_LOAD, s, n, freq, dur, $urandom_range(255));
  endtask

  function automatic int pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return 1;
    if (r < 95) return 2;
    return $urandom_range(3, 255);
  endfunction

  task automatic build_melody(int s, int len);
    if (len < bms_pkg::NOTES_PER_SOUND) load_slot(s, len, 0, $urandom_range(255));
    for (int n = len - 1; n >= 0; n--)
      load_slot(s, n, $urandom_range(1, 65535), pick_duration());
  endtask

  task automatic run_episode(int ep);
    int s;
    int other;
    int span;
    int r;
    if (ep == 0) s = 15;
    else if (ep == 1) s = 0;
    else begin
      s = $urandom_range(15);
      if (ep == 5) build_melody(s, bms_pkg::NOTES_PER_SOUND);
      else if ($urandom_range(3) != 0 || !written[s * bms_pkg::NOTES_PER_SOUND])
        build_melody(s, $urandom_range(1, 6));
    end
    play_sound(s, $urandom_range(255));
    span = (ep == 5) ? 220 : $urandom_range(150, 400);
    repeat (span) begin
      r = $urandom_range(99);
      other = $urandom_range(15);
      if (r < 92) tick_n(1);
      else if (r < 97)
        load_slot(other, $urandom_range(63), $urandom_range(65535), $urandom_range(255));
      else if (r < 98) stop_play();
      else if (r < 99 && written[other * bms_pkg::NOTES_PER_SOUND])
        play_sound(other, $urandom_range(255));
      else play_sound(s, $urandom_range(255));
    end
  endtask

  initial begin
    int ep;
    foreach (written[i]) written[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tick_n(1);
    stop_play();
    load_slot(0, 2, 0, 255);
    load_slot(0, 1, 65535, 0);
    load_slot(0, 0, 1, 1);
    load_slot(15, 63, 65535, 255);
    load_slot(15, 62, 0, 0);
    load_slot(15, 0, 0, 0);
    play_sound(0, 255);
    tick_n(1);
    play_sound(15, 0);
    stop_play();
    tick_n(2);
    play_sound(0, 0);
    stop_play();

    ep = 0;
    while (items_sent < RANDOM_ITEMS + 16) begin
      src_idle_pct = (ep == 2 || ep == 4) ? 0 : 37;
      snk_idle_pct = (ep == 2 || ep == 4) ? 0 : 37;
      if (ep == 3) hold_output = 1'b1;
      run_episode(ep);
      ep++;
    end
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
